FILE: hdl/aslf_pkg.sv
package aslf_pkg;

   localparam int LINE_CAPACITY_DEF = 256;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_BQ    = 8'h60;

   typedef enum logic [2:0] {
      QK_NONE   = 3'd0,
      QK_SINGLE = 3'd1,
      QK_DOUBLE = 3'd2,
      QK_BACK   = 3'd3,
      QK_ANGLE  = 3'd4
   } quote_kind_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       char_valid;
      logic       line_done;
      logic       line_returned;
      logic       continued_line;
   } rsp_word_type;

   typedef struct packed {
      quote_kind_type quote_kind;
      logic           skipping;
      logic           got_content;
      logic [7:0]     held_char;
      logic           held_valid;
   } line_state_type;

   localparam line_state_type LINE_STATE_CLEAR = '{
      quote_kind:  QK_NONE,
      skipping:    1'b0,
      got_content: 1'b0,
      held_char:   8'h00,
      held_valid:  1'b0
   };

endpackage

FILE: hdl/aslf_step.sv
module aslf_step import aslf_pkg::*; #(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
   parameter int CNT_W         = $clog2(LINE_CAPACITY)
) (
   input  req_word_type   req_word,
   input  logic           tasm_mode,
   input  line_state_type cur_state,
   input  logic [CNT_W-1:0] cur_count,
   output line_state_type nxt_state,
   output logic [CNT_W-1:0] nxt_count,
   output logic           rsp_fire,
   output rsp_word_type   rsp_word
);

   localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(LINE_CAPACITY - 1);

   quote_kind_type   qk_v;
   quote_kind_type   kind_v;
   logic             skip_v;
   logic             line_end;
   logic             cont_v;
   logic             is_cr;
   logic             held_bsl;
   logic [CNT_W-1:0] count_inc;

   assign held_bsl  = cur_state.held_valid && (cur_state.held_char == CH_BSL);
   assign count_inc = cur_count + CNT_W'(1);

   always_comb begin
      qk_v     = cur_state.quote_kind;
      skip_v   = cur_state.skipping;
      kind_v   = QK_NONE;
      line_end = 1'b0;
      cont_v   = 1'b0;
      is_cr    = 1'b0;
      case (req_word.in_char)
         CH_TAB, CH_SPACE: begin
            if (tasm_mode && (cur_state.quote_kind == QK_NONE) && held_bsl) begin
               skip_v = 1'b1;
            end
         end
         CH_SQ, CH_DQ, CH_BQ: begin
            if (req_word.in_char == CH_SQ) begin
               kind_v = QK_SINGLE;
            end else if (req_word.in_char == CH_DQ) begin
               kind_v = QK_DOUBLE;
            end else begin
               kind_v = QK_BACK;
            end
            if (cur_state.quote_kind == QK_NONE) begin
               qk_v = kind_v;
            end else if (cur_state.quote_kind == kind_v) begin
               qk_v = QK_NONE;
            end
         end
         CH_LT: begin
            if (cur_state.quote_kind == QK_NONE) begin
               qk_v = QK_ANGLE;
            end
         end
         CH_GT: begin
            if (cur_state.quote_kind == QK_ANGLE) begin
               qk_v = QK_NONE;
            end
         end
         CH_SEMI: begin
            if (cur_state.quote_kind == QK_NONE) begin
               skip_v = 1'b1;
            end
         end
         CH_CR: begin
            is_cr = 1'b1;
         end
         CH_LF: begin
            if (held_bsl) begin
               cont_v = 1'b1;
            end else begin
               line_end = 1'b1;
            end
         end
         CH_NUL: begin
            line_end = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      nxt_state = cur_state;
      nxt_count = cur_count;
      rsp_fire  = 1'b0;
      rsp_word  = '0;
      if (req_word.end_of_input || line_end) begin
         // release held character with the line end, then clear
         rsp_fire               = 1'b1;
         rsp_word.out_char      = cur_state.held_valid ? cur_state.held_char : 8'h00;
         rsp_word.char_valid    = cur_state.held_valid;
         rsp_word.line_done     = 1'b1;
         rsp_word.line_returned = req_word.end_of_input ? cur_state.got_content : 1'b1;
         nxt_state              = LINE_STATE_CLEAR;
         nxt_count              = '0;
      end else if (cont_v) begin
         // drop the backslash and keep the line going
         rsp_fire                = 1'b1;
         rsp_word.continued_line = 1'b1;
         nxt_state.held_valid    = 1'b0;
         nxt_state.held_char     = 8'h00;
         nxt_state.skipping      = 1'b0;
         if (cur_count != '0) begin
            nxt_count = cur_count - CNT_W'(1);
         end
      end else if (!is_cr) begin
         nxt_state.quote_kind = qk_v;
         nxt_state.skipping   = skip_v;
         if (!skip_v) begin
            rsp_fire              = cur_state.held_valid;
            rsp_word.out_char     = cur_state.held_valid ? cur_state.held_char : 8'h00;
            rsp_word.char_valid   = cur_state.held_valid;
            nxt_state.held_char   = req_word.in_char;
            nxt_state.held_valid  = 1'b1;
            nxt_state.got_content = 1'b1;
            nxt_count             = count_inc;
            if (count_inc >= COUNT_LAST) begin
               nxt_state.skipping = 1'b1;
            end
         end
      end
   end

endmodule

FILE: hdl/aslf_rsp_buf.sv
module aslf_rsp_buf import aslf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_word_type push_word,
   output logic         space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   rsp_word_type head_ff;
   rsp_word_type head_in;
   rsp_word_type tail_ff;
   rsp_word_type tail_in;
   logic         pop;

   assign space     = (count_ff != 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = head_ff;
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (pop) begin
         if (count_ff == 2'd2) begin
            head_in = tail_ff;
         end else if (push) begin
            head_in = push_word;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            head_in = push_word;
         end else begin
            tail_in = push_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

FILE: hdl/asm_source_line_filter_core.sv
// Assembler source line filter: takes one source character per clock on the
// req_ channel while the result buffer has room, and returns released line
// characters, line ends and continuation marks on the rsp_ channel, at most
// one word per character. Sustained rate is one character per cycle when the
// rsp_ side does not stall; a character's word goes from the input register
// through the single-pass filter step into a two-word result buffer. The
// filter state advances once per character, so the per-character step sets
// the rate.
// csr_wdata selects TASM mode; write it only while the block is idle.
module asm_source_line_filter_core import aslf_pkg::*; #(
   parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_wdata
);

   localparam int CNT_W = $clog2(LINE_CAPACITY);

   logic             tasm_mode_ff;
   logic             in_valid_ff;
   req_word_type     in_word_ff;
   line_state_type   state_ff;
   line_state_type   state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             step_fire;
   rsp_word_type     step_word;
   logic             buf_space;
   logic             consume;

   aslf_step #(
      .LINE_CAPACITY (LINE_CAPACITY),
      .CNT_W         (CNT_W)
   ) u_step (
      .req_word  (in_word_ff),
      .tasm_mode (tasm_mode_ff),
      .cur_state (state_ff),
      .cur_count (count_ff),
      .nxt_state (state_in),
      .nxt_count (count_in),
      .rsp_fire  (step_fire),
      .rsp_word  (step_word)
   );

   aslf_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (consume && step_fire),
      .push_word (step_word),
      .space     (buf_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign consume   = in_valid_ff && (!step_fire || buf_space);
   assign req_ready = !in_valid_ff || consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         tasm_mode_ff <= 1'b0;
         in_valid_ff  <= 1'b0;
         state_ff     <= LINE_STATE_CLEAR;
         count_ff     <= '0;
      end else begin
         if (csr_we) begin
            tasm_mode_ff <= csr_wdata;
         end
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (consume) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
   end

endmodule

FILE: hdl/aslf_checker.sv
module aslf_checker import aslf_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed while stalled");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.char_valid |-> rsp_data.out_char == 8'h00)
      else $error("character set without char_valid");

   a_returned_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.line_returned |-> rsp_data.line_done)
      else $error("line_returned without line_done");

   a_cont_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.continued_line |->
         !rsp_data.line_done && !rsp_data.char_valid)
      else $error("continuation word carries more than the mark");

endmodule

bind asm_source_line_filter_core aslf_checker u_aslf_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: sim/tb_asm_source_line_filter_core.sv
`timescale 1ns / 1ps

import aslf_pkg::*;

class line_filter_board;
   bit             tasm_mode;
   quote_kind_type quote_kind;
   bit             skipping;
   bit             got_content;
   bit             held_valid;
   logic [7:0]     held_char;
   int             stored_count;
   rsp_word_type   expected_words[$];
   int             error_count;

   function new();
      tasm_mode = 1'b0;
      error_count = 0;
      clear_line();
   endfunction

   function void clear_line();
      quote_kind = QK_NONE;
      skipping = 1'b0;
      got_content = 1'b0;
      held_valid = 1'b0;
      held_char = 8'h00;
      stored_count = 0;
   endfunction

   function void push_word(logic [7:0] ch, bit valid, bit done, bit returned, bit cont);
      rsp_word_type w;
      w.out_char = valid ? ch : 8'h00;
      w.char_valid = valid;
      w.line_done = done;
      w.line_returned = done && returned;
      w.continued_line = cont;
      expected_words.push_back(w);
   endfunction

   function void close_line(bit returned);
      push_word(held_char, held_valid, 1'b1, returned, 1'b0);
      clear_line();
   endfunction

   function void toggle_quote(quote_kind_type kind);
      if (quote_kind == QK_NONE) begin
         quote_kind = kind;
      end else if (quote_kind == kind) begin
         quote_kind = QK_NONE;
      end
   endfunction

   function void take_char(req_word_type w);
      if (w.end_of_input) begin
         close_line(got_content);
         return;
      end
      case (w.in_char)
         CH_TAB, CH_SPACE: begin
            if (tasm_mode && quote_kind == QK_NONE && held_valid && held_char == CH_BSL)
               skipping = 1'b1;
         end
         CH_SQ: toggle_quote(QK_SINGLE);
         CH_DQ: toggle_quote(QK_DOUBLE);
         CH_BQ: toggle_quote(QK_BACK);
         CH_LT: begin
            if (quote_kind == QK_NONE) quote_kind = QK_ANGLE;
         end
         CH_GT: begin
            if (quote_kind == QK_ANGLE) quote_kind = QK_NONE;
         end
         CH_SEMI: begin
            if (quote_kind == QK_NONE) skipping = 1'b1;
         end
         CH_CR: return;
         CH_LF: begin
            if (held_valid && held_char == CH_BSL) begin
               held_valid = 1'b0;
               held_char = 8'h00;
               if (stored_count > 0) stored_count--;
               skipping = 1'b0;
               push_word(8'h00, 1'b0, 1'b0, 1'b0, 1'b1);
               return;
            end
            close_line(1'b1);
            return;
         end
         CH_NUL: begin
            close_line(1'b1);
            return;
         end
         default: ;
      endcase
      if (!skipping) begin
         if (held_valid) push_word(held_char, 1'b1, 1'b0, 1'b0, 1'b0);
         held_char = w.in_char;
         held_valid = 1'b1;
         got_content = 1'b1;
         stored_count++;
         if (stored_count + 1 >= LINE_CAPACITY_DEF) skipping = 1'b1;
      end
   endfunction

   function void compare_field(string name, int exp_value, int act_value);
      if (exp_value != act_value) begin
         $display("%0t %s mismatch: expected %h, actual %h", $time, name, exp_value,
                  act_value);
         error_count++;
      end
   endfunction

   function void check_word(rsp_word_type got);
      rsp_word_type exp_word;
      if (expected_words.size() == 0) begin
         $display("%0t unexpected word: expected none, actual %h", $time, got);
         error_count++;
         return;
      end
      exp_word = expected_words.pop_front();
      compare_field("out_char", int'(exp_word.out_char), int'(got.out_char));
      compare_field("char_valid", int'(exp_word.char_valid), int'(got.char_valid));
      compare_field("line_done", int'(exp_word.line_done), int'(got.line_done));
      compare_field("line_returned", int'(exp_word.line_returned),
                    int'(got.line_returned));
      compare_field("continued_line", int'(exp_word.continued_line),
                    int'(got.continued_line));
   endfunction
endclass

module tb_asm_source_line_filter_core;
   localparam int CYCLE_LIMIT = 500000;
   localparam int PHASE_CHARS = 370;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_we = 1'b0;
   logic         csr_wdata = 1'b0;

   line_filter_board board = new();
   int unsigned      cycle_count = 0;
   int               chars_sent = 0;
   bit               send_calm = 1'b0;
   bit               take_calm = 1'b0;

   asm_source_line_filter_core #(
      .LINE_CAPACITY(LINE_CAPACITY_DEF)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_word(rsp_data);
         if (req_valid && req_ready) board.take_char(req_data);
      end
   end

   initial begin
      int gap;
      forever begin
         if ($urandom_range(0, 40) == 0) take_calm = !take_calm;
         gap = take_calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_word(input req_word_type w);
      int gap;
      if ($urandom_range(0, 40) == 0) send_calm = !send_calm;
      gap = send_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (!req_ready);
      if (w.end_of_input || w.in_char != CH_CR) chars_sent++;
   endtask

   task automatic send_char(input logic [7:0] ch);
      req_word_type w;
      w.in_char = ch;
      w.end_of_input = 1'b0;
      send_word(w);
   endtask

   task automatic send_end();
      req_word_type w;
      w.in_char = 8'($urandom_range(0, 255));
      w.end_of_input = 1'b1;
      send_word(w);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic write_mode(input bit mode);
      csr_we <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
      board.tasm_mode = mode;
   endtask

   // hold the sender until every expected word is back and the pipe is empty
   task automatic drain();
      req_valid <= 1'b0;
      while (board.expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // fill to capacity, continue past it, then fill again
   task automatic send_full_line();
      repeat (LINE_CAPACITY_DEF - 2) send_char(8'h61);
      send_text("\\zz\nbc\n");
   endtask

   function automatic logic [7:0] pick_char(input bit plain);
      int r;
      if (plain && $urandom_range(0, 9) != 0) return 8'($urandom_range(8'h61, 8'h7A));
      r = $urandom_range(0, 19);
      case (r)
         8:       return CH_SPACE;
         9:       return CH_TAB;
         10:      return CH_SQ;
         11:      return CH_DQ;
         12:      return CH_BQ;
         13:      return CH_LT;
         14:      return CH_GT;
         15:      return CH_SEMI;
         16, 19:  return CH_BSL;
         17:      return CH_CR;
         18:      return 8'($urandom_range(0, 255));
         default: return 8'($urandom_range(8'h21, 8'h7E));
      endcase
   endfunction

   task automatic send_random_line();
      int len;
      len = ($urandom_range(0, 59) == 0) ? $urandom_range(240, 300) : $urandom_range(0, 20);
      for (int i = 0; i < len; i++) send_char(pick_char(len > 100));
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4, 5, 6: send_char(CH_LF);
         7:       send_char(CH_NUL);
         8:       send_end();
         9, 10: begin
            send_char(CH_BSL);
            send_char(CH_LF);
         end
         default: send_char(8'($urandom_range(0, 255)));
      endcase
   endtask

   initial begin
      int target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      send_end();
      send_char(8'hFF);
      send_char(CH_CR);
      send_end();
      send_text("<'>;>a;z\n");
      send_text("\"`'\"x\n");
      send_text("a\\\n\n");
      send_char(CH_NUL);
      drain();

      write_mode(1'b1);
      send_text("x\\ y\n\\\n q");
      send_char(CH_NUL);
      send_text("'\\\tk'\n");
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         write_mode(phase[0] ? 1'b0 : 1'b1);
         if (phase == 0) send_full_line();
         target = chars_sent + PHASE_CHARS;
         while (chars_sent < target) send_random_line();
         drain();
      end

      if (board.error_count == 0 && board.expected_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

FILE: asm_source_line_filter_core.f
hdl/aslf_pkg.sv
hdl/aslf_step.sv
hdl/aslf_rsp_buf.sv
hdl/asm_source_line_filter_core.sv
hdl/aslf_checker.sv
sim/tb_asm_source_line_filter_core.sv
